// ===== hdl/wsp_pkg.sv =====
// Shared types, constants and helpers of the wave surface point evaluator.
`default_nettype none
package wsp_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_W = 21;
	localparam int OUT_W = 32;
	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_AMP = 2'd0;
	localparam logic [1:0] REG_FREQ_B = 2'd1;
	localparam logic [1:0] REG_FREQ_C = 2'd2;

	localparam logic signed [IN_W-1:0] AMP_RST = 21'sd98304;
	localparam logic signed [IN_W-1:0] FREQ_B_RST = 21'sd32768;
	localparam logic signed [IN_W-1:0] FREQ_C_RST = 21'sd65536;

	// Turns per radian scaled by 2^32, quarter turn in radians in Q30, and one in Q30.
	localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;
	localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
	localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

	localparam int NSTEP = 5;
	localparam int SC_LAT = 20;
	localparam int CMB_LAT = 4;
	localparam int QDEPTH = 4;
	localparam int ODEPTH = 32;

	localparam logic [31:0] SIN_DIV [NSTEP-1] = '{32'd72, 32'd42, 32'd20, 32'd6};
	localparam logic [31:0] COS_DIV [NSTEP] = '{32'd90, 32'd56, 32'd30, 32'd12, 32'd2};
	localparam logic [31:0] SIN_RCP [NSTEP-1] = '{
		32'(64'h1_0000_0000 / 64'd72), 32'(64'h1_0000_0000 / 64'd42),
		32'(64'h1_0000_0000 / 64'd20), 32'(64'h1_0000_0000 / 64'd6)};
	localparam logic [31:0] COS_RCP [NSTEP] = '{
		32'(64'h1_0000_0000 / 64'd90), 32'(64'h1_0000_0000 / 64'd56),
		32'(64'h1_0000_0000 / 64'd30), 32'(64'h1_0000_0000 / 64'd12),
		32'(64'h1_0000_0000 / 64'd2)};

	typedef struct packed {
		logic signed [IN_W-1:0] u_coord;
		logic signed [IN_W-1:0] v_coord;
	} wsp_pt_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] pos_z;
		logic signed [OUT_W-1:0] du_z;
		logic signed [OUT_W-1:0] dv_z;
		logic signed [OUT_W-1:0] norm_x;
		logic signed [OUT_W-1:0] norm_y;
		logic signed [OUT_W-1:0] duu_z;
		logic signed [OUT_W-1:0] duv_z;
		logic signed [OUT_W-1:0] dvv_z;
	} wsp_res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wsp_qstat_t;

	function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return signed'(v[OUT_W-1:0]);
	endfunction
endpackage
`default_nettype wire

// ===== hdl/wsp_front.sv =====
// Front end: configuration registers and input beat acceptance into the point queue.
`default_nettype none
module wsp_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [wsp_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic signed [wsp_pkg::IN_W-1:0] u_coord,
	input  wire logic signed [wsp_pkg::IN_W-1:0] v_coord,
	input  wire wsp_pkg::wsp_qstat_t            qstat,
	output logic                                q_wr,
	output wsp_pkg::wsp_pt_t                    q_wdata,
	output logic signed [wsp_pkg::IN_W-1:0]     amp_a,
	output logic signed [wsp_pkg::IN_W-1:0]     freq_b,
	output logic signed [wsp_pkg::IN_W-1:0]     freq_c
);
	import wsp_pkg::*;

	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_a <= AMP_RST;
			freq_b <= FREQ_B_RST;
			freq_c <= FREQ_C_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_AMP:    amp_a <= signed'(pwdata[IN_W-1:0]);
				REG_FREQ_B: freq_b <= signed'(pwdata[IN_W-1:0]);
				REG_FREQ_C: freq_c <= signed'(pwdata[IN_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_AMP:    prdata = 32'(amp_a);
			REG_FREQ_B: prdata = 32'(freq_b);
			REG_FREQ_C: prdata = 32'(freq_c);
			default:    prdata = '0;
		endcase
	end

	assign full = qstat.full;
	assign q_wr = push && !qstat.full;
	assign q_wdata.u_coord = u_coord;
	assign q_wdata.v_coord = v_coord;
endmodule
`default_nettype wire

// ===== hdl/wsp_queue.sv =====
// Short point queue between the front end and the evaluation pipeline.
`default_nettype none
module wsp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire wsp_pkg::wsp_pt_t wdata,
	input  wire logic             rd,
	output wsp_pkg::wsp_pt_t      rdata,
	output wsp_pkg::wsp_qstat_t   stat
);
	import wsp_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	wsp_pt_t       ent_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

	assign rdata = ent_q[rp_q];
	assign stat.full = (cnt_q == (PW+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
endmodule
`default_nettype wire

// ===== hdl/wsp_sincos.sv =====
// Pipelined sine and cosine of coef*arg in Q30 by quarter-turn reduction and series.
`default_nettype none
module wsp_sincos #(
	parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic signed [wsp_pkg::IN_W-1:0] coef,
	input  wire logic signed [wsp_pkg::IN_W-1:0] arg,
	output logic signed [31:0]                   sin_q30,
	output logic signed [31:0]                   cos_q30
);
	import wsp_pkg::*;

	localparam int PW = 2 * IN_W;
	localparam int TW = PW - FRAC_BITS;
	localparam int KW = (TW + 31 > FRAC_BITS + 32) ? TW + 31 : FRAC_BITS + 32;
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	logic signed [PW-1:0] ca_s1;
	logic signed [TW-1:0] t;
	logic signed [KW-1:0] tk_s2;
	logic [31:0]          p;
	logic [1:0]           quad;
	logic [31:0]          r;
	logic signed [60:0]   dh_s3;
	logic [1:0]           q_s3;
	logic signed [30:0]   x;
	logic signed [61:0]   xx_s4;
	logic signed [30:0]   x_s4;
	logic [1:0]           q_s4;
	logic signed [31:0]   x2_s4;

	logic signed [31:0] hs_c [NSTEP];
	logic signed [31:0] hc_c [NSTEP];
	logic signed [31:0] x2_c [NSTEP];
	logic signed [30:0] x_c [NSTEP];
	logic [1:0]         q_c [NSTEP];

	always_ff @(posedge clk)
		ca_s1 <= coef * arg;

	assign t = signed'(ca_s1[PW-1:FRAC_BITS]);

	always_ff @(posedge clk)
		tk_s2 <= KW'(t) * KW'(TURN_PER_RAD);

	// Phase in turns; the residual after the nearest quarter turn fits 30 bits.
	assign p = tk_s2[FRAC_BITS+31:FRAC_BITS];
	assign quad = 2'((p + 32'h2000_0000) >> 30);
	assign r = p - {quad, 30'b0};

	always_ff @(posedge clk) begin
		dh_s3 <= 61'(signed'(r[29:0])) * 61'(HALF_PI_Q30);
		q_s3 <= quad;
	end

	assign x = dh_s3[60:30];

	always_ff @(posedge clk) begin
		xx_s4 <= 62'(x) * 62'(x);
		x_s4 <= x;
		q_s4 <= q_s3;
	end

	assign x2_s4 = signed'({1'b0, xx_s4[60:30]});

	// Each series step: multiply, reciprocal estimate, one-step correction.
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic signed [31:0] hs_in, hc_in, x2_in;
		logic signed [30:0] x_in;
		logic [1:0]         q_in;
		logic signed [63:0] ps, pc;
		logic signed [31:0] ms_a, mc_a, x2_a, ms_b, mc_b, x2_b;
		logic signed [30:0] x_a, x_b;
		logic [1:0]         q_a, q_b;
		logic [63:0]        qcp;
		logic [31:0]        qc_b, rc;

		if (k == 0) begin : g_first
			assign hs_in = Q30_ONE;
			assign hc_in = Q30_ONE;
			assign x2_in = x2_s4;
			assign x_in = x_s4;
			assign q_in = q_s4;
		end else begin : g_next
			assign hs_in = hs_c[k-1];
			assign hc_in = hc_c[k-1];
			assign x2_in = x2_c[k-1];
			assign x_in = x_c[k-1];
			assign q_in = q_c[k-1];
		end

		assign pc = 64'(x2_in) * 64'(hc_in);
		if (k < NSTEP - 1) begin : g_sin_ser
			assign ps = 64'(x2_in) * 64'(hs_in);
		end else begin : g_sin_fin
			assign ps = 64'(x_in) * 64'(hs_in);
		end

		always_ff @(posedge clk) begin
			ms_a <= signed'(ps[61:30]);
			mc_a <= signed'(pc[61:30]);
			x2_a <= x2_in;
			x_a <= x_in;
			q_a <= q_in;
		end

		assign qcp = {32'b0, mc_a} * {32'b0, COS_RCP[k]};

		always_ff @(posedge clk) begin
			qc_b <= qcp[63:32];
			ms_b <= ms_a;
			mc_b <= mc_a;
			x2_b <= x2_a;
			x_b <= x_a;
			q_b <= q_a;
		end

		assign rc = mc_b - qc_b * COS_DIV[k];

		always_ff @(posedge clk) begin
			hc_c[k] <= Q30_ONE - signed'(qc_b + 32'(rc >= COS_DIV[k]));
			x2_c[k] <= x2_b;
			x_c[k] <= x_b;
			q_c[k] <= q_b;
		end

		if (k < NSTEP - 1) begin : g_sin_div
			logic [63:0] qsp;
			logic [31:0] qs_b, rs;

			assign qsp = {32'b0, ms_a} * {32'b0, SIN_RCP[k]};
			always_ff @(posedge clk)
				qs_b <= qsp[63:32];
			assign rs = ms_b - qs_b * SIN_DIV[k];
			always_ff @(posedge clk)
				hs_c[k] <= Q30_ONE - signed'(qs_b + 32'(rs >= SIN_DIV[k]));
		end else begin : g_sin_out
			always_ff @(posedge clk)
				hs_c[k] <= ms_b;
		end
	end

	always_ff @(posedge clk) begin
		case (q_c[NSTEP-1])
			QUAD_0: begin
				sin_q30 <= hs_c[NSTEP-1];
				cos_q30 <= hc_c[NSTEP-1];
			end
			QUAD_1: begin
				sin_q30 <= hc_c[NSTEP-1];
				cos_q30 <= -hs_c[NSTEP-1];
			end
			QUAD_2: begin
				sin_q30 <= -hs_c[NSTEP-1];
				cos_q30 <= -hc_c[NSTEP-1];
			end
			default: begin
				sin_q30 <= -hc_c[NSTEP-1];
				cos_q30 <= hs_c[NSTEP-1];
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/wsp_back.sv =====
// Back end: evaluation pipeline, result products and the result queue with credit control.
`default_nettype none
module wsp_back #(
	parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic signed [wsp_pkg::IN_W-1:0] amp_a,
	input  wire logic signed [wsp_pkg::IN_W-1:0] freq_b,
	input  wire logic signed [wsp_pkg::IN_W-1:0] freq_c,
	input  wire wsp_pkg::wsp_qstat_t             qstat,
	input  wire wsp_pkg::wsp_pt_t                q_data,
	output logic                                 q_pop,
	output wsp_pkg::wsp_res_t                    res,
	output logic                                 empty,
	input  wire logic                            pop
);
	import wsp_pkg::*;

	localparam int LAT = SC_LAT + CMB_LAT;
	localparam int OPW = $clog2(ODEPTH);
	localparam int M1W = 2 * IN_W + 1 - FRAC_BITS;
	localparam int M2W = M1W + IN_W - FRAC_BITS;

	logic               issue;
	logic               take;
	logic [OPW:0]       cnt_q;
	logic [OPW:0]       ocnt_q;
	logic [OPW-1:0]     wp_q;
	logic [OPW-1:0]     rp_q;
	logic [LAT-1:0]     vld_q;
	wsp_res_t           ent_q [ODEPTH];
	wsp_res_t           wres;

	logic signed [31:0] sbu, cbu, scv, ccv;
	logic signed [63:0] pcc, psc, pcs, pss;
	logic signed [31:0] cc_c1, sc_c1, cs_c1, ss_c1;
	logic signed [52:0] acc, asc, acs, ass;
	logic signed [21:0] pz_c2, gu_c2, gv_c2, guv_c2;
	logic signed [42:0] pzb, pzc, gub, gvc, guvb;
	logic signed [M1W-1:0] pzb_c3, pzc_c3, du_c3, dv_c3, duvb_c3;
	logic signed [21:0] pz_c3, pz_c4;
	logic signed [M1W+IN_W-1:0] pzbb, pzcc, duvbc;
	logic signed [M2W-1:0] pzbb_c4, pzcc_c4, duv_c4;
	logic signed [M1W-1:0] du_c4, dv_c4;

	// A point enters only while the result queue has room for everything in flight.
	assign issue = !qstat.empty && (cnt_q < (OPW+1)'(ODEPTH));
	assign q_pop = issue;
	assign take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vld_q <= '0;
		end else begin
			cnt_q <= cnt_q + (OPW+1)'(issue) - (OPW+1)'(take);
			vld_q <= {vld_q[LAT-2:0], issue};
		end
	end

	wsp_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_u (
		.clk     (clk),
		.coef    (freq_b),
		.arg     (q_data.u_coord),
		.sin_q30 (sbu),
		.cos_q30 (cbu)
	);

	wsp_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_v (
		.clk     (clk),
		.coef    (freq_c),
		.arg     (q_data.v_coord),
		.sin_q30 (scv),
		.cos_q30 (ccv)
	);

	assign pcc = 64'(cbu) * 64'(ccv);
	assign psc = 64'(sbu) * 64'(ccv);
	assign pcs = 64'(cbu) * 64'(scv);
	assign pss = 64'(sbu) * 64'(scv);

	always_ff @(posedge clk) begin
		cc_c1 <= signed'(pcc[61:30]);
		sc_c1 <= signed'(psc[61:30]);
		cs_c1 <= signed'(pcs[61:30]);
		ss_c1 <= signed'(pss[61:30]);
	end

	assign acc = 53'(amp_a) * 53'(cc_c1);
	assign asc = 53'(amp_a) * 53'(sc_c1);
	assign acs = 53'(amp_a) * 53'(cs_c1);
	assign ass = 53'(amp_a) * 53'(ss_c1);

	always_ff @(posedge clk) begin
		pz_c2 <= signed'(acc[51:30]);
		gu_c2 <= signed'(asc[51:30]);
		gv_c2 <= signed'(acs[51:30]);
		guv_c2 <= signed'(ass[51:30]);
	end

	assign pzb = 43'(pz_c2) * 43'(freq_b);
	assign pzc = 43'(pz_c2) * 43'(freq_c);
	assign gub = 43'(gu_c2) * 43'(freq_b);
	assign gvc = 43'(gv_c2) * 43'(freq_c);
	assign guvb = 43'(guv_c2) * 43'(freq_b);

	always_ff @(posedge clk) begin
		pzb_c3 <= signed'(pzb[42:FRAC_BITS]);
		pzc_c3 <= signed'(pzc[42:FRAC_BITS]);
		du_c3 <= signed'(gub[42:FRAC_BITS]);
		dv_c3 <= signed'(gvc[42:FRAC_BITS]);
		duvb_c3 <= signed'(guvb[42:FRAC_BITS]);
		pz_c3 <= pz_c2;
	end

	assign pzbb = (M1W+IN_W)'(pzb_c3) * (M1W+IN_W)'(freq_b);
	assign pzcc = (M1W+IN_W)'(pzc_c3) * (M1W+IN_W)'(freq_c);
	assign duvbc = (M1W+IN_W)'(duvb_c3) * (M1W+IN_W)'(freq_c);

	always_ff @(posedge clk) begin
		pzbb_c4 <= signed'(pzbb[M1W+IN_W-1:FRAC_BITS]);
		pzcc_c4 <= signed'(pzcc[M1W+IN_W-1:FRAC_BITS]);
		duv_c4 <= signed'(duvbc[M1W+IN_W-1:FRAC_BITS]);
		du_c4 <= du_c3;
		dv_c4 <= dv_c3;
		pz_c4 <= pz_c3;
	end

	// Negations are taken on the unsaturated values before clamping.
	assign wres.pos_z = sat32(64'(pz_c4));
	assign wres.du_z = sat32(-64'(du_c4));
	assign wres.dv_z = sat32(-64'(dv_c4));
	assign wres.norm_x = sat32(64'(du_c4));
	assign wres.norm_y = sat32(64'(dv_c4));
	assign wres.duu_z = sat32(-64'(pzbb_c4));
	assign wres.duv_z = sat32(64'(duv_c4));
	assign wres.dvv_z = sat32(-64'(pzcc_c4));

	always_ff @(posedge clk) begin
		if (vld_q[LAT-1])
			ent_q[wp_q] <= wres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (vld_q[LAT-1])
				wp_q <= wp_q + 1'b1;
			if (take)
				rp_q <= rp_q + 1'b1;
			ocnt_q <= ocnt_q + (OPW+1)'(vld_q[LAT-1]) - (OPW+1)'(take);
		end
	end

	assign res = ent_q[rp_q];
	assign empty = (ocnt_q == '0);
endmodule
`default_nettype wire

// ===== hdl/wave_surface_point_eval.sv =====
// Top level of the wave surface point evaluator.
`default_nettype none
// Evaluates z = a*cos(b*u)*cos(c*v) with its first and second partial derivatives
// and the normal x/y components at one (u,v) point per beat, all in signed fixed
// point with FRAC_BITS fraction bits and every result saturated to 32 bits. A new
// point is taken every clock cycle while the point queue is not full; each result
// passes the sine and cosine series pipeline (five multiply, reciprocal and
// correction steps) and the four product stages after it. The 32-entry result
// queue covers that pipeline, so the rate stays at one point per cycle as long as
// results are popped. Write a, b and c over the register port only while no point
// is in flight.
module wave_surface_point_eval #(
	parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [wsp_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic signed [wsp_pkg::IN_W-1:0] u_coord,
	input  wire logic signed [wsp_pkg::IN_W-1:0] v_coord,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic signed [wsp_pkg::OUT_W-1:0]     pos_z,
	output logic signed [wsp_pkg::OUT_W-1:0]     du_z,
	output logic signed [wsp_pkg::OUT_W-1:0]     dv_z,
	output logic signed [wsp_pkg::OUT_W-1:0]     norm_x,
	output logic signed [wsp_pkg::OUT_W-1:0]     norm_y,
	output logic signed [wsp_pkg::OUT_W-1:0]     duu_z,
	output logic signed [wsp_pkg::OUT_W-1:0]     duv_z,
	output logic signed [wsp_pkg::OUT_W-1:0]     dvv_z
);
	import wsp_pkg::*;

	wsp_qstat_t             qstat;
	wsp_pt_t                q_wdata;
	wsp_pt_t                q_rdata;
	wsp_res_t               res;
	logic                   q_wr;
	logic                   q_pop;
	logic signed [IN_W-1:0] amp_a, freq_b, freq_c;

	wsp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.u_coord (u_coord),
		.v_coord (v_coord),
		.qstat   (qstat),
		.q_wr    (q_wr),
		.q_wdata (q_wdata),
		.amp_a   (amp_a),
		.freq_b  (freq_b),
		.freq_c  (freq_c)
	);

	wsp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.stat   (qstat)
	);

	wsp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.amp_a  (amp_a),
		.freq_b (freq_b),
		.freq_c (freq_c),
		.qstat  (qstat),
		.q_data (q_rdata),
		.q_pop  (q_pop),
		.res    (res),
		.empty  (empty),
		.pop    (pop)
	);

	assign pos_z = res.pos_z;
	assign du_z = res.du_z;
	assign dv_z = res.dv_z;
	assign norm_x = res.norm_x;
	assign norm_y = res.norm_y;
	assign duu_z = res.duu_z;
	assign duv_z = res.duv_z;
	assign dvv_z = res.dvv_z;
endmodule
`default_nettype wire
